FILE: rtl/core/pvadf_pkg.sv
// shared types, phase codes and field widths for the pva stream deframer
package pvadf_pkg;

    typedef enum logic [4:0] {
        PH_HUNT, PH_A, PH_V, PH_TYPE, PH_CNT, PH_RSV, PH_FLAGS, PH_SZH, PH_SZL,
        PH_VPTS, PH_PRE, PH_DATA, PH_HOLD, PH_ASKIP, PH_APFL, PH_AHLEN, PH_AHDR
    } phase_t;

    localparam int PTS_W     = 33;
    localparam int MAX_RES   = 3;
    localparam int RES_CNT_W = 2;

    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_V      = 8'h56;
    localparam logic [7:0] SYNC_BYTE   = 8'h55;
    localparam logic [7:0] FLAG_PTS    = 8'h10;
    localparam logic [7:0] PES_PTS_FLG = 8'h80;
    localparam logic [7:0] TYPE_VIDEO  = 8'h01;
    localparam logic [7:0] TYPE_AUDIO  = 8'h02;

    localparam logic [1:0] CFG_LIMIT = 2'd0;
    localparam logic [1:0] CFG_VEN   = 2'd1;
    localparam logic [1:0] CFG_AEN   = 2'd2;
    localparam logic [1:0] CFG_FIX   = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_LOST    = 1'b1;

    // one result word, tdata fields without tlast
    typedef struct packed {
        logic              seg_end;
        logic              new_pts;
        logic              seg_start;
        logic [PTS_W-1:0]  pts_ticks;
        logic              stream_kind;
        logic [7:0]        data_byte;
        logic              kind;
    } res_t;

    // up to three results made from one input word
    typedef struct packed {
        logic [RES_CNT_W-1:0] cnt;
        res_t [MAX_RES-1:0]   res;
    } res_group_t;

endpackage

FILE: rtl/core/pvadf_out.sv
// output buffer: holds one group of up to three results and sends them one by one
module pvadf_out (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  grp_valid,
    input  pvadf_pkg::res_group_t grp,
    output logic                  grp_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output pvadf_pkg::res_t       m_res,
    output logic                  m_last
);
    import pvadf_pkg::*;

    res_group_t           grp_reg;
    logic                 full_reg;
    logic [RES_CNT_W-1:0] idx_reg;
    logic                 fin;

    assign m_tvalid  = full_reg;
    assign m_res     = grp_reg.res[idx_reg];
    assign m_last    = (idx_reg == grp_reg.cnt - RES_CNT_W'(1));
    assign fin       = full_reg && m_tready && m_last;
    assign grp_ready = !full_reg || fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (grp_ready) begin
            full_reg <= grp_valid && (grp.cnt != '0);
            idx_reg  <= '0;
        end else if (m_tready) begin
            idx_reg <= idx_reg + RES_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_ready) begin
            grp_reg <= grp;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (grp_reg.cnt != '0)) else $error("buffer holds empty group");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (idx_reg < grp_reg.cnt)) else $error("result index past count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(idx_reg)) else $error("index moved while stalled");

endmodule

FILE: rtl/core/pva_stream_deframer_top.sv
// top level of the pva stream deframer: byte parser and result buffer
// the first result word of an accepted input word is offered in the cycle after
// throughput: one input word per cycle while each gives at most one result and m_tready
//   is high; a word with several results holds the input until all have been sent
// reset: synchronous active-low aresetn returns to sync hunting, clears pts state
//   and restores register defaults (limit 6144, all enables on)
module pva_stream_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value [7:0]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // kind, data_byte, stream_kind, pts_ticks[32:0],
                                   // segment_start, new_pts, segment_end, zero pad
    output logic        m_tlast,   // last result of this input word
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import pvadf_pkg::*;

    // configuration registers
    logic [15:0] limit_reg;
    logic        ven_reg, aen_reg, fix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 16'd6144;
            ven_reg   <= 1'b1;
            aen_reg   <= 1'b1;
            fix_reg   <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_LIMIT: limit_reg <= cfg_wdata;
                CFG_VEN:   ven_reg   <= cfg_wdata[0];
                CFG_AEN:   aen_reg   <= cfg_wdata[0];
                CFG_FIX:   fix_reg   <= cfg_wdata[0];
                default:   ;
            endcase
        end
    end

    // parser state
    phase_t      phase_reg, phase_next;
    logic [31:0] win_reg, win_next;
    logic [15:0] scnt_reg, scnt_next;
    logic [7:0]  ptype_reg, ptype_next;
    logic [7:0]  pflags_reg, pflags_next;
    logic [15:0] psize_reg, psize_next;
    logic [15:0] left_reg, left_next;
    logic [39:0] asm_reg, asm_next;
    logic [7:0]  pesfl_reg, pesfl_next;
    logic [7:0]  hleft_reg, hleft_next;
    logic [23:0] hold_reg, hold_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [1:0]  pre_reg, pre_next;
    logic [PTS_W-1:0] pvpts_reg, pvpts_next;
    logic [PTS_W-1:0] vpts_reg, vpts_next;
    logic [PTS_W-1:0] apts_reg, apts_next;
    logic        vknown_reg, vknown_next;
    logic        aknown_reg, aknown_next;
    logic [2:0]  pcnt_reg, pcnt_next;
    logic        first_reg, first_next;
    logic        fresh_reg, fresh_next;
    logic        pesok_reg, pesok_next;

    res_group_t grp;
    logic       grp_ready;
    logic       take;
    res_t       m_res;

    assign s_tready = grp_ready;
    assign take     = s_tvalid && s_tready;

    // candidate results are built with the current stream and pts
    function automatic res_t mk(input logic [7:0] b, input logic sk, input logic [PTS_W-1:0] p,
                                input logic st, input logic np, input logic en);
        res_t r;
        r.kind = KIND_PAYLOAD; r.data_byte = b; r.stream_kind = sk; r.pts_ticks = p;
        r.seg_start = st; r.new_pts = np; r.seg_end = en;
        return r;
    endfunction

    logic [7:0] b;
    logic       endp;
    logic       vid_ok, aud_ok;
    logic       fin_pes, pts_good;
    logic [PTS_W-1:0] apts_dec;
    logic       rel_hold;
    logic [1:0] rel_cnt;
    logic       rel_end;

    always_comb begin
        b        = s_tdata;
        vid_ok   = (ptype_reg == TYPE_VIDEO) && ven_reg;
        aud_ok   = (ptype_reg == TYPE_AUDIO) && aen_reg;
        phase_next = phase_reg; win_next = win_reg; scnt_next = scnt_reg;
        ptype_next = ptype_reg; pflags_next = pflags_reg; psize_next = psize_reg;
        left_next = left_reg; asm_next = asm_reg; pesfl_next = pesfl_reg;
        hleft_next = hleft_reg; hold_next = hold_reg; hcnt_next = hcnt_reg;
        pre_next = pre_reg; pvpts_next = pvpts_reg; vpts_next = vpts_reg;
        apts_next = apts_reg; vknown_next = vknown_reg; aknown_next = aknown_reg;
        pcnt_next = pcnt_reg; first_next = first_reg; fresh_next = fresh_reg;
        pesok_next = pesok_reg;
        grp = '0;
        endp = 1'b0;
        fin_pes = 1'b0;
        rel_hold = 1'b0; rel_cnt = 2'd0; rel_end = 1'b0;
        pts_good = 1'b0;
        apts_dec = '0;

        if (s_tuser) begin
            // resync: forget pts and hunt
            vknown_next = 1'b0; aknown_next = 1'b0;
            phase_next = PH_HUNT; win_next = '0; scnt_next = '0;
        end else begin
            if (phase_reg >= PH_VPTS) begin
                left_next = left_reg - 16'd1;
                endp = (left_next == '0);
            end
            case (phase_reg)
                PH_HUNT: begin
                    if (win_reg[31:24] == CHAR_A && win_reg[23:16] == CHAR_V
                        && b == SYNC_BYTE) begin
                        ptype_next = win_reg[15:8];
                        scnt_next = '0;
                        phase_next = PH_FLAGS;
                    end else begin
                        scnt_next = scnt_reg + 16'd1;
                        if (scnt_next == limit_reg) begin
                            scnt_next = '0;
                            grp.cnt = 2'd1;
                            grp.res[0] = '0;
                            grp.res[0].kind = KIND_LOST;
                        end
                    end
                    win_next = {win_reg[23:0], b};
                end
                PH_A: begin win_next = {24'd0, b}; phase_next = PH_V; end
                PH_V: begin
                    if (win_reg[7:0] == CHAR_A && b == CHAR_V) begin
                        phase_next = PH_TYPE;
                    end else begin
                        phase_next = PH_HUNT; win_next = '0; scnt_next = '0;
                    end
                end
                PH_TYPE: begin ptype_next = b; phase_next = PH_CNT; end
                PH_CNT:  phase_next = PH_RSV;
                PH_RSV:  phase_next = PH_FLAGS;
                PH_FLAGS: begin pflags_next = b; phase_next = PH_SZH; end
                PH_SZH: begin psize_next = {b, 8'd0}; phase_next = PH_SZL; end
                PH_SZL: begin
                    psize_next = {psize_reg[15:8], b};
                    left_next = psize_next;
                    if (psize_next == '0) begin
                        phase_next = PH_A;
                    end else if (ptype_reg == TYPE_VIDEO && (pflags_reg & FLAG_PTS) != '0) begin
                        phase_next = PH_VPTS; pcnt_next = '0; asm_next = '0;
                    end else if (ptype_reg == TYPE_AUDIO && (pflags_reg & FLAG_PTS) != '0) begin
                        phase_next = PH_ASKIP; hleft_next = 8'd7;
                    end else if (ptype_reg == TYPE_AUDIO && fix_reg) begin
                        phase_next = PH_HOLD; hcnt_next = '0; hold_next = '0;
                    end else begin
                        phase_next = PH_DATA; first_next = 1'b1; fresh_next = 1'b0;
                    end
                end
                PH_VPTS: begin
                    asm_next = {asm_reg[31:0], b};
                    pcnt_next = pcnt_reg + 3'd1;
                    if (pcnt_next == 3'd4) begin
                        pvpts_next = {1'b0, asm_next[31:0]};
                        pre_next = pflags_reg[1:0];
                        if (pre_next != '0) begin
                            phase_next = PH_PRE; first_next = 1'b1; fresh_next = 1'b0;
                        end else begin
                            vpts_next = pvpts_next; vknown_next = 1'b1;
                            phase_next = PH_DATA; first_next = 1'b1; fresh_next = 1'b1;
                        end
                    end
                end
                PH_PRE, PH_DATA: begin
                    if (vid_ok && vknown_reg) begin
                        grp.cnt = 2'd1;
                        grp.res[0] = mk(b, 1'b0, vpts_reg, first_reg, fresh_reg,
                                        endp || (phase_reg == PH_PRE && pre_reg == 2'd1));
                    end else if (aud_ok && aknown_reg) begin
                        grp.cnt = 2'd1;
                        grp.res[0] = mk(b, 1'b1, apts_reg, first_reg, fresh_reg,
                                        endp || (phase_reg == PH_PRE && pre_reg == 2'd1));
                    end
                    first_next = 1'b0;
                    if (phase_reg == PH_PRE) begin
                        pre_next = pre_reg - 2'd1;
                        if (pre_next == '0) begin
                            vpts_next = pvpts_reg; vknown_next = 1'b1;
                            phase_next = PH_DATA; first_next = 1'b1; fresh_next = 1'b1;
                        end
                    end
                end
                PH_HOLD: begin
                    hold_next = {hold_reg[15:0], b};
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hcnt_next == 2'd3) begin
                        if (hold_next == 24'h000001) begin
                            phase_next = PH_ASKIP; hleft_next = 8'd4;
                        end else begin
                            rel_hold = 1'b1; rel_cnt = 2'd3; rel_end = endp;
                            phase_next = PH_DATA; first_next = 1'b0; fresh_next = 1'b0;
                        end
                    end
                end
                PH_ASKIP: begin
                    hleft_next = hleft_reg - 8'd1;
                    if (hleft_next == '0) phase_next = PH_APFL;
                end
                PH_APFL: begin pesfl_next = b; phase_next = PH_AHLEN; end
                PH_AHLEN: begin
                    hleft_next = b; pcnt_next = '0; asm_next = '0;
                    pesok_next = (pesfl_reg & PES_PTS_FLG) != '0 && b >= 8'd5;
                    if (b == '0) fin_pes = 1'b1;
                    else phase_next = PH_AHDR;
                end
                PH_AHDR: begin
                    if (pcnt_reg < 3'd5) begin
                        asm_next = {asm_reg[31:0], b};
                        pcnt_next = pcnt_reg + 3'd1;
                    end
                    hleft_next = hleft_reg - 8'd1;
                    if (hleft_next == '0) fin_pes = 1'b1;
                end
                default: begin
                    phase_next = PH_HUNT; win_next = '0; scnt_next = '0;
                end
            endcase

            if (fin_pes) begin
                pts_good = pesok_next && (asm_next[39:36] == 4'h2);
                apts_dec = {asm_next[35:33], asm_next[31:24], asm_next[23:17],
                            asm_next[15:8], asm_next[7:1]};
                if (pts_good) begin
                    apts_next = apts_dec; aknown_next = 1'b1;
                end
                phase_next = PH_DATA; first_next = 1'b1; fresh_next = pts_good;
            end

            if (endp) begin
                if (phase_next == PH_PRE) begin
                    vpts_next = pvpts_next; vknown_next = 1'b1;
                end else if (phase_next == PH_HOLD) begin
                    rel_hold = 1'b1; rel_cnt = hcnt_next; rel_end = 1'b1;
                end
                phase_next = PH_A;
            end

            // held bytes leave as audio of this packet, pts state as before this word
            if (rel_hold) begin
                fresh_next = 1'b0;
                if (ptype_reg == TYPE_AUDIO && aen_reg && aknown_reg) begin
                    grp.cnt = rel_cnt;
                    for (int i = 0; i < MAX_RES; i++) begin
                        if (2'(i) < rel_cnt) begin
                            grp.res[i] = mk(hold_next[8*(rel_cnt-2'd1-2'(i)) +: 8], 1'b1,
                                            apts_reg, i == 0, 1'b0,
                                            rel_end && (2'(i) == rel_cnt - 2'd1));
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT; win_reg <= '0; scnt_reg <= '0; ptype_reg <= '0;
            pflags_reg <= '0; psize_reg <= '0; left_reg <= '0; asm_reg <= '0;
            pesfl_reg <= '0; hleft_reg <= '0; hold_reg <= '0; hcnt_reg <= '0;
            pre_reg <= '0; pvpts_reg <= '0; vpts_reg <= '0; apts_reg <= '0;
            vknown_reg <= 1'b0; aknown_reg <= 1'b0; pcnt_reg <= '0;
            first_reg <= 1'b0; fresh_reg <= 1'b0; pesok_reg <= 1'b0;
        end else if (take) begin
            phase_reg <= phase_next; win_reg <= win_next; scnt_reg <= scnt_next;
            ptype_reg <= ptype_next; pflags_reg <= pflags_next; psize_reg <= psize_next;
            left_reg <= left_next; asm_reg <= asm_next; pesfl_reg <= pesfl_next;
            hleft_reg <= hleft_next; hold_reg <= hold_next; hcnt_reg <= hcnt_next;
            pre_reg <= pre_next; pvpts_reg <= pvpts_next; vpts_reg <= vpts_next;
            apts_reg <= apts_next; vknown_reg <= vknown_next; aknown_reg <= aknown_next;
            pcnt_reg <= pcnt_next; first_reg <= first_next; fresh_reg <= fresh_next;
            pesok_reg <= pesok_next;
        end
    end

    pvadf_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grp_valid (take),
        .grp       (grp),
        .grp_ready (grp_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res),
        .m_last    (m_tlast)
    );

    assign m_tdata = {2'b00, m_res.seg_end, m_res.new_pts, m_res.seg_start, m_res.pts_ticks,
                      m_res.stream_kind, m_res.data_byte, m_res.kind};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_tuser) |=> (phase_reg == PH_HUNT && !vknown_reg && !aknown_reg))
        else $error("resync did not clear pts state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0] == KIND_LOST) |-> (m_tdata[47:1] == '0))
        else $error("sync lost word carries payload");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && phase_reg == PH_HUNT && !s_tuser) |=>
        (phase_reg == PH_HUNT || phase_reg == PH_FLAGS))
        else $error("hunt left to wrong phase");

endmodule

FILE: tb/tb_pva_stream_deframer_top.sv
// self-checking testbench for the pva stream deframer top level
module tb_pva_stream_deframer_top;
    import pvadf_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // byte_value [7:0]
    logic        s_tuser;   // action
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // kind, data_byte, stream_kind, pts_ticks, seg start, new pts, seg end
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    pva_stream_deframer_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // one expected result word and its end-of-input marker
    typedef struct {
        res_t r;
        bit   tl;
    } out_word_t;

    out_word_t expected_words[$];
    out_word_t step_words[$];
    int        fail_count = 0;
    int        cycle_count = 0;
    int        words_sent = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;

    // shadow registers
    logic [15:0] lim_sh;
    bit          ven_sh, aen_sh, fix_sh;

    // shadow parser state
    phase_t      ph;
    logic [31:0] win;
    logic [15:0] scnt, psize, left;
    logic [7:0]  ptype, pflags, pesf, pesleft;
    logic [39:0] pasm;
    logic [23:0] hold;
    logic [1:0]  hcnt, precnt;
    logic [32:0] pend_vpts, vpts, apts;
    bit          vknown, aknown, sfirst, snew, pesok;
    int          pcnt;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // ---------------- predictor ----------------

    function automatic void push_word(logic k, logic [7:0] b, logic sk, logic [32:0] pts,
                                      logic st, logic np, logic en);
        out_word_t w;
        w.r.kind = k; w.r.data_byte = b; w.r.stream_kind = sk; w.r.pts_ticks = pts;
        w.r.seg_start = st; w.r.new_pts = np; w.r.seg_end = en; w.tl = 1'b0;
        step_words.push_back(w);
    endfunction

    // payload byte leaves only for an enabled stream whose pts is known
    function automatic void emit_payload(logic [7:0] b, logic st, logic en);
        if (ptype == TYPE_VIDEO && ven_sh && vknown)
            push_word(KIND_PAYLOAD, b, 1'b0, vpts, st, snew, en);
        else if (ptype == TYPE_AUDIO && aen_sh && aknown)
            push_word(KIND_PAYLOAD, b, 1'b1, apts, st, snew, en);
    endfunction

    function automatic void take_video_pts();
        vpts = pend_vpts;
        vknown = 1'b1;
    endfunction

    function automatic void enter_payload(bit fresh);
        ph = PH_DATA; sfirst = 1'b1; snew = fresh;
    endfunction

    function automatic void flush_hold(int cnt, bit en);
        snew = 1'b0;
        for (int i = 0; i < cnt; i++)
            emit_payload(8'(hold >> (8 * (cnt - 1 - i))), i == 0, en && i == cnt - 1);
    endfunction

    // pes header done: pts taken only when flagged, long enough and marker nibble is 2
    function automatic void close_pes();
        bit ok;
        ok = pesok && pasm[39:36] == 4'h2;
        if (ok) begin
            apts = {pasm[35:33], pasm[31:24], pasm[23:17], pasm[15:8], pasm[7:1]};
            aknown = 1'b1;
        end
        enter_payload(ok);
    endfunction

    function automatic void restart_hunt();
        ph = PH_HUNT; win = '0; scnt = '0;
    endfunction

    function automatic void reset_shadow();
        lim_sh = 16'd6144; ven_sh = 1; aen_sh = 1; fix_sh = 1;
        ph = PH_HUNT; win = '0; scnt = '0; ptype = '0; pflags = '0; psize = '0; left = '0;
        pesf = '0; pesleft = '0; hold = '0; hcnt = '0; precnt = '0; pasm = '0;
        pend_vpts = '0; vpts = '0; apts = '0; vknown = 0; aknown = 0;
        pcnt = 0; sfirst = 0; snew = 0; pesok = 0;
    endfunction

    // results caused by one accepted input word land in step_words
    function automatic void predict_word(bit act, logic [7:0] b);
        bit en;
        en = 0;
        step_words.delete();
        if (act) begin
            vknown = 0; aknown = 0;
            restart_hunt();
            return;
        end
        if (ph >= PH_VPTS) begin
            left = left - 16'd1;
            en = (left == 0);
        end
        case (ph)
            PH_HUNT: begin
                if (win[31:24] == CHAR_A && win[23:16] == CHAR_V && b == SYNC_BYTE) begin
                    ptype = win[15:8]; scnt = '0; ph = PH_FLAGS;
                end else begin
                    scnt = scnt + 16'd1;
                    if (scnt == lim_sh) begin
                        scnt = '0;
                        push_word(KIND_LOST, 8'd0, 1'b0, 33'd0, 1'b0, 1'b0, 1'b0);
                    end
                end
                win = {win[23:0], b};
            end
            PH_A: begin
                win = {24'd0, b}; ph = PH_V;
            end
            PH_V: begin
                if (win[7:0] == CHAR_A && b == CHAR_V) ph = PH_TYPE;
                else restart_hunt();
            end
            PH_TYPE: begin ptype = b; ph = PH_CNT; end
            PH_CNT:  ph = PH_RSV;
            PH_RSV:  ph = PH_FLAGS;
            PH_FLAGS: begin pflags = b; ph = PH_SZH; end
            PH_SZH: begin psize = {b, 8'd0}; ph = PH_SZL; end
            PH_SZL: begin
                psize[7:0] = b; left = psize;
                if (psize == 0) ph = PH_A;
                else if (ptype == TYPE_VIDEO && (pflags & FLAG_PTS) != 0) begin
                    ph = PH_VPTS; pcnt = 0; pasm = '0;
                end else if (ptype == TYPE_AUDIO && (pflags & FLAG_PTS) != 0) begin
                    ph = PH_ASKIP; pesleft = 8'd7;
                end else if (ptype == TYPE_AUDIO && fix_sh) begin
                    ph = PH_HOLD; hcnt = '0; hold = '0;
                end else enter_payload(0);
            end
            PH_VPTS: begin
                pasm = {pasm[31:0], b};
                pcnt++;
                if (pcnt == 4) begin
                    pend_vpts = {1'b0, pasm[31:0]};
                    precnt = pflags[1:0];
                    if (precnt != 0) begin
                        ph = PH_PRE; sfirst = 1; snew = 0;
                    end else begin
                        take_video_pts(); enter_payload(1);
                    end
                end
            end
            PH_PRE: begin
                emit_payload(b, sfirst, en || precnt == 2'd1);
                sfirst = 0;
                precnt = precnt - 2'd1;
                if (precnt == 0) begin
                    take_video_pts(); enter_payload(1);
                end
            end
            PH_DATA: begin
                emit_payload(b, sfirst, en);
                sfirst = 0;
            end
            PH_HOLD: begin
                hold = {hold[15:0], b};
                hcnt = hcnt + 2'd1;
                if (hcnt == 2'd3) begin
                    if (hold == 24'h000001) begin
                        ph = PH_ASKIP; pesleft = 8'd4;
                    end else begin
                        flush_hold(3, en);
                        ph = PH_DATA; sfirst = 0; snew = 0;
                    end
                end
            end
            PH_ASKIP: begin
                pesleft = pesleft - 8'd1;
                if (pesleft == 0) ph = PH_APFL;
            end
            PH_APFL: begin pesf = b; ph = PH_AHLEN; end
            PH_AHLEN: begin
                pesleft = b; pcnt = 0; pasm = '0;
                pesok = (pesf & PES_PTS_FLG) != 0 && b >= 8'd5;
                if (b == 0) close_pes();
                else ph = PH_AHDR;
            end
            PH_AHDR: begin
                if (pcnt < 5) begin
                    pasm = {pasm[31:0], b};
                    pcnt++;
                end
                pesleft = pesleft - 8'd1;
                if (pesleft == 0) close_pes();
            end
            default: restart_hunt();
        endcase
        if (en) begin
            if (ph == PH_PRE) take_video_pts();
            else if (ph == PH_HOLD) flush_hold(hcnt, 1);
            ph = PH_A;
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].tl = 1'b1;
    endfunction

    // ---------------- sender ----------------

    // lost_typed: the expectation is the hand-written sync-lost word
    task automatic send_word(bit act, logic [7:0] b, bit lost_typed = 0);
        out_word_t w;
        while (chance(idle_pct)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        predict_word(act, b);
        if (lost_typed) begin
            w.r = '0; w.r.kind = KIND_LOST; w.tl = 1'b1;
            expected_words.push_back(w);
        end else begin
            foreach (step_words[i]) expected_words.push_back(step_words[i]);
        end
    endtask

    // register writes only with nothing in flight
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LIMIT: lim_sh = val;
            CFG_VEN:   ven_sh = val[0];
            CFG_AEN:   aen_sh = val[0];
            default:   fix_sh = val[0];
        endcase
    endtask

    task automatic send_packet(logic [7:0] ptyp, logic [7:0] flags, logic [7:0] body[$]);
        int sz;
        sz = body.size();
        // now and then the size field cuts the packet short
        if (sz > 0 && chance(12)) sz = $urandom_range(sz - 1);
        send_word(0, CHAR_A);
        send_word(0, CHAR_V);
        send_word(0, ptyp);
        send_word(0, 8'($urandom_range(255)));
        send_word(0, SYNC_BYTE);
        send_word(0, flags);
        send_word(0, 8'(sz >> 8));
        send_word(0, 8'(sz));
        for (int i = 0; i < sz; i++) send_word(0, body[i]);
    endtask

    task automatic random_video();
        logic [7:0] body[$];
        logic [7:0] flags;
        flags = chance(85) ? (FLAG_PTS | 8'($urandom_range(3))) : 8'($urandom_range(255));
        if (flags & FLAG_PTS) begin
            repeat (4) body.push_back(8'($urandom_range(255)));
            repeat (flags[1:0]) body.push_back(8'($urandom_range(255)));
        end
        repeat ($urandom_range(6)) body.push_back(8'($urandom_range(255)));
        send_packet(TYPE_VIDEO, flags, body);
    endtask

    task automatic random_audio();
        logic [7:0] body[$];
        logic [7:0] flags;
        int hl;
        flags = chance(60) ? FLAG_PTS : 8'(chance(50) ? 0 : $urandom_range(255) & ~FLAG_PTS);
        if (chance(80)) begin
            // pes start code, stream id, length, first flag byte
            body = '{8'h00, 8'h00, 8'h01, 8'hc0, 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'h80};
            body.push_back(chance(85) ? PES_PTS_FLG : 8'($urandom_range(255)));
            hl = chance(75) ? 5 : $urandom_range(8);
            body.push_back(8'(hl));
            for (int i = 0; i < hl; i++)
                body.push_back(i == 0 && chance(85) ? {4'h2, 3'($urandom_range(7)), 1'b1}
                                                    : 8'($urandom_range(255)));
        end
        repeat ($urandom_range(6)) body.push_back(8'($urandom_range(255)));
        send_packet(TYPE_AUDIO, flags, body);
    endtask

    task automatic random_traffic(int n);
        int goal;
        logic [7:0] body[$];
        goal = words_sent + n;
        while (words_sent < goal) begin
            case ($urandom_range(19))
                0: send_word(1, 8'($urandom_range(255)));           // resync
                1: repeat ($urandom_range(1, 6)) send_word(0, 8'($urandom_range(255)));
                2: begin                                            // unknown packet type
                    body.delete();
                    repeat ($urandom_range(5)) body.push_back(8'($urandom_range(255)));
                    send_packet(8'($urandom_range(3, 255)), 8'($urandom_range(255)), body);
                end
                3, 4, 5, 6, 7, 8, 9, 10: random_video();
                default: random_audio();
            endcase
        end
    endtask

    // ---------------- directed rows ----------------

    typedef struct {
        bit         act;
        logic [7:0] b;
        bit         lost;   // hand-written sync-lost expectation
    } stim_row_t;

    stim_row_t dir_rows[] = '{
        '{0, 8'h12, 1}, '{1, 8'hff, 0},
        // hunt with a one-byte limit: every non-sync byte reports sync loss
        '{0, 8'h41, 1}, '{0, 8'h56, 1}, '{0, 8'h01, 1}, '{0, 8'h00, 1}, '{0, 8'h55, 0},
        // video with pts and one prebyte, then two payload bytes at the extremes
        '{0, 8'h11, 0}, '{0, 8'h00, 0}, '{0, 8'h07, 0},
        '{0, 8'hff, 0}, '{0, 8'hff, 0}, '{0, 8'hff, 0}, '{0, 8'hff, 0},
        '{0, 8'h5a, 0}, '{0, 8'h00, 0}, '{0, 8'hff, 0},
        // audio packet of size zero, then a bad sync word
        '{0, 8'h41, 0}, '{0, 8'h56, 0}, '{0, 8'h02, 0}, '{0, 8'h00, 0}, '{0, 8'h55, 0},
        '{0, 8'h00, 0}, '{0, 8'h00, 0}, '{0, 8'h00, 0},
        '{0, 8'h41, 0}, '{0, 8'h00, 0}
    };

    // ---------------- receiver and checker ----------------

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pva_stream_deframer_top: mismatch");
            $finish;
        end
        m_tready <= !chance(stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                fail_count++;
            end else begin
                out_word_t w;
                res_t got;
                w = expected_words.pop_front();
                got = res_t'(m_tdata[45:0]);
                if (got.kind !== w.r.kind) begin
                    $error("kind exp %0d got %0d", w.r.kind, got.kind); fail_count++;
                end
                if (got.data_byte !== w.r.data_byte) begin
                    $error("data_byte exp %h got %h", w.r.data_byte, got.data_byte);
                    fail_count++;
                end
                if (got.stream_kind !== w.r.stream_kind) begin
                    $error("stream_kind exp %0d got %0d", w.r.stream_kind, got.stream_kind);
                    fail_count++;
                end
                if (got.pts_ticks !== w.r.pts_ticks) begin
                    $error("pts_ticks exp %h got %h", w.r.pts_ticks, got.pts_ticks);
                    fail_count++;
                end
                if (got.seg_start !== w.r.seg_start) begin
                    $error("segment_start exp %0d got %0d", w.r.seg_start, got.seg_start);
                    fail_count++;
                end
                if (got.new_pts !== w.r.new_pts) begin
                    $error("new_pts exp %0d got %0d", w.r.new_pts, got.new_pts);
                    fail_count++;
                end
                if (got.seg_end !== w.r.seg_end) begin
                    $error("segment_end exp %0d got %0d", w.r.seg_end, got.seg_end);
                    fail_count++;
                end
                if (m_tlast !== w.tl) begin
                    $error("last exp %0d got %0d", w.tl, m_tlast); fail_count++;
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        m_tready = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        reset_shadow();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part runs with the smallest search limit
        write_reg(CFG_LIMIT, 16'd1);
        foreach (dir_rows[i]) send_word(dir_rows[i].act, dir_rows[i].b, dir_rows[i].lost);
        write_reg(CFG_LIMIT, 16'd16);

        // no idling
        random_traffic(40);
        // sender mostly idle, video off, largest limit
        write_reg(CFG_VEN, 16'd0);
        write_reg(CFG_LIMIT, 16'hffff);
        idle_pct = 88;
        random_traffic(40);
        // receiver mostly stalled, audio off, fix off, video back
        write_reg(CFG_VEN, 16'd1);
        write_reg(CFG_AEN, 16'd0);
        write_reg(CFG_FIX, 16'd0);
        write_reg(CFG_LIMIT, 16'd3);
        idle_pct = 0; stall_pct = 88;
        random_traffic(40);
        // both sides idling, audio and fix back on, limit 6
        write_reg(CFG_AEN, 16'd1);
        write_reg(CFG_FIX, 16'd1);
        write_reg(CFG_LIMIT, 16'd6);
        idle_pct = 35; stall_pct = 35;
        random_traffic(40);
        idle_pct = 0; stall_pct = 0;
        random_traffic(10);

        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("pva_stream_deframer_top: match");
        else
            $display("pva_stream_deframer_top: mismatch");
        $finish;
    end

endmodule
